@@ hdl/running_mean_variance_assert.svh @@
// ----------------------------------------------------------------------------
// Running mean and variance assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RMV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RMV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance package
// Formats, sequencer states, arithmetic unit codes and small helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmv_pkg;

	localparam int COUNT_BITS = 32;
	localparam int SAMPLE_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int MEAN_EXTRA = 16;
	localparam int MEAN_BITS = SAMPLE_BITS + MEAN_EXTRA;
	localparam int WORD_BITS = 64;
	localparam int VAR_BITS = 48;
	localparam int SE_BITS = 32;
	localparam int STEP_BITS = 6;
	localparam int STEPS_WIDE = 64;
	localparam int STEPS_ROOT = 32;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} rmv_op_t;

	typedef struct packed {
		logic    start;
		rmv_op_t op;
	} rmv_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PREP,
		ST_A_DIV,
		ST_A_MAG,
		ST_A_MUL,
		ST_M_SQ,
		ST_M_A,
		ST_M_DIV1,
		ST_M_B,
		ST_M_DIV2,
		ST_M_TM,
		ST_M_MMUL,
		ST_M_MDIV,
		ST_V_CHK,
		ST_V_DIV,
		ST_S_CHK,
		ST_S_DIV,
		ST_S_SQRT,
		ST_OUT
	} rmv_state_t;

	typedef struct packed {
		logic                 neg;
		logic [WORD_BITS-1:0] mag;
	} rmv_diff_t;

	// Magnitude and sign of a - b for two signed means.
	function automatic rmv_diff_t diff_mag(input logic signed [MEAN_BITS-1:0] a,
	                                       input logic signed [MEAN_BITS-1:0] b);
		logic signed [MEAN_BITS:0] d;
		rmv_diff_t r;
		d = $signed({a[MEAN_BITS-1], a}) - $signed({b[MEAN_BITS-1], b});
		r.neg = d[MEAN_BITS];
		r.mag = WORD_BITS'(r.neg ? $unsigned(-d) : $unsigned(d));
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] add_sat(input logic [WORD_BITS-1:0] a,
	                                                input logic [WORD_BITS-1:0] b);
		logic [WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_BITS] ? '1 : s[WORD_BITS-1:0];
	endfunction

	// 128-bit product shifted right by 48, saturated to 64 bits.
	function automatic logic [WORD_BITS-1:0] prod_shift(input logic [WORD_BITS-1:0] hi,
	                                                   input logic [WORD_BITS-1:0] lo);
		return (hi[WORD_BITS-1:VAR_BITS] != '0) ? '1 :
			{hi[VAR_BITS-1:0], lo[WORD_BITS-1:VAR_BITS]};
	endfunction

endpackage

@@ hdl/rmv_arith.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance shared arithmetic unit
// Bit-serial multiply, restoring divide and integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmv_arith import rmv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmv_req_t             req,
	input  logic [WORD_BITS-1:0] opa,     // multiplicand, dividend high or radicand
	input  logic [WORD_BITS-1:0] opb,     // multiplier or dividend low
	input  logic [WORD_BITS-1:0] opc,     // divisor
	output logic                 done,
	output logic [WORD_BITS-1:0] res_hi,  // product high or remainder
	output logic [WORD_BITS-1:0] res_lo   // product low, quotient or root
);

	rmv_op_t              op_q;
	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic [WORD_BITS-1:0] hi_q, lo_q, d_q, bit_q;
	logic                 last;
	logic [WORD_BITS:0]   mul_sum;
	logic [WORD_BITS-1:0] div_sh;
	logic                 div_take;
	logic [WORD_BITS-1:0] rt_try;

	assign last = (op_q == OP_SQRT) ? (cnt_q == STEP_BITS'(STEPS_ROOT - 1))
	                                : (cnt_q == STEP_BITS'(STEPS_WIDE - 1));

	always_comb begin
		mul_sum  = lo_q[0] ? ({1'b0, hi_q} + {1'b0, d_q}) : {1'b0, hi_q};
		div_sh   = {hi_q[WORD_BITS-2:0], lo_q[WORD_BITS-1]};
		div_take = hi_q[WORD_BITS-1] || (div_sh >= d_q);
		rt_try   = lo_q + bit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= req.op;
		end else begin
			done_q <= busy_q && last;
			if (busy_q) begin
				cnt_q <= cnt_q + STEP_BITS'(1);
				if (last) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				OP_MUL: begin
					hi_q <= '0;
					lo_q <= opb;
					d_q  <= opa;
				end
				OP_DIV: begin
					hi_q <= opa;
					lo_q <= opb;
					d_q  <= opc;
				end
				OP_SQRT: begin
					hi_q  <= opa;
					lo_q  <= '0;
					bit_q <= WORD_BITS'(1) << (WORD_BITS - 2);
				end
				default: begin
					hi_q <= '0;
					lo_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					hi_q <= mul_sum[WORD_BITS:1];
					lo_q <= {mul_sum[0], lo_q[WORD_BITS-1:1]};
				end
				OP_DIV: begin
					hi_q <= div_take ? (div_sh - d_q) : div_sh;
					lo_q <= {lo_q[WORD_BITS-2:0], div_take};
				end
				OP_SQRT: begin
					if (hi_q >= rt_try) begin
						hi_q <= hi_q - rt_try;
						lo_q <= (lo_q >> 1) + bit_q;
					end else begin
						lo_q <= lo_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
				default: begin
					hi_q <= hi_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign res_hi = hi_q;
	assign res_lo = lo_q;

endmodule

@@ hdl/running_mean_variance.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance accumulator
// Welford sample update and Chan merge with variance and standard error.
// ----------------------------------------------------------------------------
// The block holds a sample count, a Q16.32 running mean and a Q48.16 sum of
// squared deviations. Each input beat either adds one sample (tuser 0) or
// merges a partial accumulator (tuser 1), and yields exactly one output beat
// with the new count, the Q16.16 mean, the Q32.16 sample variance, the Q16.16
// standard error and the validity and status flags. All multiplies, divides
// and the square root run through one shared bit-serial unit under a small
// sequencer, one bit per cycle, so one beat is in flight at a time and
// s_tready is low until the result has been taken. An add beat runs one
// divide and one multiply for the update, then the variance divide, the
// scaled divide and the root; a merge runs five multiplies and three
// divides before the same tail. When the standard error saturates, the
// scaled divide and the root are skipped. A rejected or trivial beat skips
// the update and goes straight to the variance check; any beat that leaves
// fewer than two samples skips the variance and standard error steps.
`timescale 1ns / 1ps

module running_mean_variance import rmv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sample [31:0], part_count [63:32], other_mean [95:64], other_m2 [159:96]
	input  logic [159:0] s_tdata,
	// func [0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// total_count [31:0], mean_value [63:32], variance_value [111:64],
	// std_error [143:112]
	output logic [143:0] m_tdata,
	// mean_valid [0], variance_valid [1], status [2]
	output logic [2:0]   m_tuser
);

	// Sequencer state and architectural accumulator.
	rmv_state_t                   state_q, state_d;
	logic                         issue_q;
	logic [COUNT_BITS-1:0]        cnt_q;
	logic signed [MEAN_BITS-1:0]  mean_q;
	logic [WORD_BITS-1:0]         dev_q;

	// Captured input beat.
	logic                         func_q;
	logic [SAMPLE_BITS-1:0]       smp_q;
	logic [COUNT_BITS-1:0]        ocnt_q;
	logic [SAMPLE_BITS-1:0]       omean_q;
	logic [WORD_BITS-1:0]         om2_q;

	// Working registers between unit operations.
	logic [WORD_BITS-1:0]         mag_q, mag2_q, t_q, r_q;
	logic                         neg_q;
	logic [COUNT_BITS-1:0]        tot_q;
	logic [VAR_BITS-1:0]          var_q;
	logic [SE_BITS-1:0]           se_q;
	logic                         status_q;

	// Shared unit connection.
	rmv_req_t                     req;
	rmv_op_t                      op;
	logic [WORD_BITS-1:0]         opa, opb, opc;
	logic                         u_done;
	logic [WORD_BITS-1:0]         u_hi, u_lo;

	logic signed [MEAN_BITS-1:0]  x_val, om_val, mean_upd;
	rmv_diff_t                    dx, dom, dx2;
	logic                         compute_d;

	assign x_val  = {smp_q, MEAN_EXTRA'(0)};
	assign om_val = {omean_q, MEAN_EXTRA'(0)};
	assign dx     = diff_mag(x_val, mean_q);
	assign dom    = diff_mag(om_val, mean_q);
	assign dx2    = diff_mag(x_val, mean_q);
	assign mean_upd = neg_q ? (mean_q - u_lo[MEAN_BITS-1:0]) : (mean_q + u_lo[MEAN_BITS-1:0]);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_PREP;
			ST_PREP: begin
				if (!func_q) begin
					state_d = (cnt_q == COUNT_MAX) ? ST_V_CHK : ST_A_DIV;
				end else if (ocnt_q == '0 || cnt_q == '0 || cnt_q > COUNT_MAX - ocnt_q) begin
					state_d = ST_V_CHK;
				end else begin
					state_d = ST_M_SQ;
				end
			end
			ST_A_DIV:  if (u_done) state_d = ST_A_MAG;
			ST_A_MAG:  state_d = ST_A_MUL;
			ST_A_MUL:  if (u_done) state_d = ST_V_CHK;
			ST_M_SQ:   if (u_done) state_d = ST_M_A;
			ST_M_A:    if (u_done) state_d = ST_M_DIV1;
			ST_M_DIV1: if (u_done) state_d = ST_M_B;
			ST_M_B:    if (u_done) state_d = ST_M_DIV2;
			ST_M_DIV2: if (u_done) state_d = ST_M_TM;
			ST_M_TM:   if (u_done) state_d = ST_M_MMUL;
			ST_M_MMUL: if (u_done) state_d = ST_M_MDIV;
			ST_M_MDIV: if (u_done) state_d = ST_V_CHK;
			ST_V_CHK:  state_d = (cnt_q < COUNT_BITS'(2)) ? ST_OUT : ST_V_DIV;
			ST_V_DIV:  if (u_done) state_d = ST_S_CHK;
			ST_S_CHK: begin
				state_d = (COUNT_BITS'(u_lo[WORD_BITS-1:VAR_BITS]) >= cnt_q) ? ST_OUT : ST_S_DIV;
			end
			ST_S_DIV:  if (u_done) state_d = ST_S_SQRT;
			ST_S_SQRT: if (u_done) state_d = ST_OUT;
			ST_OUT:    if (m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_d)
			ST_A_DIV, ST_A_MUL, ST_M_SQ, ST_M_A, ST_M_DIV1, ST_M_B, ST_M_DIV2,
			ST_M_TM, ST_M_MMUL, ST_M_MDIV, ST_V_DIV, ST_S_DIV, ST_S_SQRT:
				compute_d = (state_d != state_q);
			default: compute_d = 1'b0;
		endcase
	end

	// Unit operands and handshake outputs.
	always_comb begin
		op  = OP_MUL;
		opa = '0;
		opb = '0;
		opc = '0;
		case (state_q)
			ST_A_DIV: begin
				op  = OP_DIV;
				opb = mag_q;
				opc = WORD_BITS'(cnt_q) + WORD_BITS'(1);
			end
			ST_A_MUL: begin
				opa = mag_q;
				opb = mag2_q;
			end
			ST_M_SQ: begin
				opa = mag_q;
				opb = mag_q;
			end
			ST_M_A: begin
				opa = t_q;
				opb = WORD_BITS'(cnt_q);
			end
			ST_M_DIV1, ST_M_DIV2, ST_M_MDIV: begin
				op  = OP_DIV;
				opa = u_hi;
				opb = u_lo;
				opc = WORD_BITS'(tot_q);
			end
			ST_M_B: begin
				opa = r_q;
				opb = WORD_BITS'(ocnt_q);
			end
			ST_M_TM: begin
				opa = t_q;
				opb = WORD_BITS'(ocnt_q);
			end
			ST_M_MMUL: begin
				opa = mag_q;
				opb = WORD_BITS'(ocnt_q);
			end
			ST_V_DIV: begin
				op  = OP_DIV;
				opb = dev_q;
				opc = WORD_BITS'(cnt_q) - WORD_BITS'(1);
			end
			ST_S_DIV: begin
				op  = OP_DIV;
				opa = WORD_BITS'(u_lo[WORD_BITS-1:VAR_BITS]);
				opb = {u_lo[VAR_BITS-1:0], FRAC_BITS'(0)};
				opc = WORD_BITS'(cnt_q);
			end
			ST_S_SQRT: begin
				op  = OP_SQRT;
				opa = u_lo;
			end
			default: begin
				op = OP_MUL;
			end
		endcase
		req.start = issue_q;
		req.op    = op;
		s_tready  = (state_q == ST_IDLE);
		m_tvalid  = (state_q == ST_OUT);
	end

	// Control and accumulator registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			cnt_q   <= '0;
			mean_q  <= '0;
			dev_q   <= '0;
		end else begin
			state_q <= state_d;
			issue_q <= compute_d;
			case (state_q)
				ST_PREP: begin
					if (func_q && ocnt_q != '0 && cnt_q == '0) begin
						cnt_q  <= ocnt_q;
						mean_q <= om_val;
						dev_q  <= om2_q;
					end
				end
				ST_A_DIV: if (u_done) mean_q <= mean_upd;
				ST_A_MUL: begin
					if (u_done) begin
						dev_q <= add_sat(dev_q, prod_shift(u_hi, u_lo));
						cnt_q <= cnt_q + COUNT_BITS'(1);
					end
				end
				ST_M_TM: begin
					if (u_done) begin
						dev_q <= add_sat(add_sat(dev_q, om2_q),
							add_sat((u_hi != '0) ? '1 : u_lo, r_q));
					end
				end
				ST_M_MDIV: begin
					if (u_done) begin
						mean_q <= mean_upd;
						cnt_q  <= tot_q;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					func_q  <= s_tuser[0];
					smp_q   <= s_tdata[31:0];
					ocnt_q  <= s_tdata[63:32];
					omean_q <= s_tdata[95:64];
					om2_q   <= s_tdata[159:96];
				end
			end
			ST_PREP: begin
				// Rejected when the add would pass the full count or the
				// merged count would not fit.
				status_q <= func_q ? (ocnt_q != '0 && cnt_q != '0 && cnt_q > COUNT_MAX - ocnt_q)
				                   : (cnt_q == COUNT_MAX);
				mag_q    <= func_q ? dom.mag : dx.mag;
				neg_q    <= func_q ? dom.neg : dx.neg;
				tot_q    <= cnt_q + ocnt_q;
			end
			ST_A_MAG: mag2_q <= dx2.mag;
			ST_M_SQ:  if (u_done) t_q <= prod_shift(u_hi, u_lo);
			ST_M_DIV1: begin
				if (u_done) begin
					t_q <= u_lo;
					r_q <= u_hi;
				end
			end
			ST_M_DIV2: if (u_done) r_q <= u_lo;
			ST_V_CHK: begin
				var_q <= '0;
				se_q  <= '0;
			end
			ST_V_DIV: begin
				if (u_done) var_q <= (u_lo[WORD_BITS-1:VAR_BITS] != '0) ? '1 : u_lo[VAR_BITS-1:0];
			end
			ST_S_CHK: se_q <= '1;
			ST_S_SQRT: if (u_done) se_q <= u_lo[SE_BITS-1:0];
			default: begin
				mag2_q <= mag2_q;
			end
		endcase
	end

	rmv_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.opc    (opc),
		.done   (u_done),
		.res_hi (u_hi),
		.res_lo (u_lo)
	);

	// The mean reads as zero while the store is empty.
	assign m_tdata = {se_q, var_q,
		(cnt_q == '0) ? SAMPLE_BITS'(0) : mean_q[MEAN_BITS-1:MEAN_EXTRA], cnt_q};
	assign m_tuser = {status_q, cnt_q >= COUNT_BITS'(2), cnt_q != '0};

endmodule

@@ hdl/rmv_checker.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance port checker
// Watches the stream ports of the accumulator for consistent behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "running_mean_variance_assert.svh"

module rmv_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic [2:0]   m_tuser
);

	// A waiting result beat holds until it is taken.
	`RMV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

	// One beat at a time: the input side stays closed while a result waits.
	`RMV_ASSERT_NOW(a_one_item, s_tready, !m_tvalid, "input open while a result is pending")

	// After an accepted beat the block goes busy.
	`RMV_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "input still open after an accepted beat")

	// Two samples imply one sample.
	`RMV_ASSERT_NOW(a_flags, m_tvalid && m_tuser[1], m_tuser[0], "variance valid without mean valid")

	// Without two samples the variance and the standard error read zero.
	`RMV_ASSERT_NOW(a_var_zero, m_tvalid && !m_tuser[1], m_tdata[143:64] == '0, "variance fields not zero")

endmodule

bind running_mean_variance rmv_checker u_rmv_checker (.*);

@@ tb/tb_running_mean_variance.sv @@
// ----------------------------------------------------------------------------
// Running mean and variance testbench
// Drives sample and merge beats and checks every result beat against an
// independent fixed-point prediction of the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_running_mean_variance;
	import rmv_pkg::*;

	localparam logic FN_ADD   = 1'b0;
	localparam logic FN_MERGE = 1'b1;

	// Expected content of one result beat.
	typedef struct {
		logic [31:0] count;
		logic [31:0] mean;
		logic        mean_ok;
		logic [47:0] variance;
		logic [31:0] std_err;
		logic        var_ok;
		logic        rejected;
	} stats_t;

	int fail_count = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
	                               input logic [63:0] want);
		$display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Accumulator prediction and the queue of results still to arrive.
	class stats_scoreboard;
		logic [31:0]  n_held;
		logic [47:0]  avg_q32;
		logic [63:0]  dev_sum;
		stats_t       pending[$];

		function new();
			n_held = '0;
			avg_q32 = '0;
			dev_sum = '0;
		endfunction

		static function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? '1 : s[63:0];
		endfunction

		// Product shifted right by 48, saturated to 64 bits.
		static function logic [63:0] scaled_prod(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = a * b;
			p = p >> 48;
			return (p[127:64] != '0) ? '1 : p[63:0];
		endfunction

		static function logic [63:0] root(logic [63:0] x);
			logic [63:0] r, b;
			r = 0;
			b = 64'h4000_0000_0000_0000;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Old mean plus or minus floor(mag * num / den).
		static function logic [47:0] move_mean(logic [47:0] avg, logic [63:0] mag, logic neg,
		                                       logic [63:0] num, logic [63:0] den);
			logic [127:0] q;
			q = (mag * {64'd0, num}) / den;
			return neg ? avg - q[47:0] : avg + q[47:0];
		endfunction

		function void note_input(logic fn, logic [31:0] x, logic [31:0] oc,
		                         logic [31:0] omean, logic [63:0] om2);
			logic signed [48:0] d;
			logic [63:0] mag, mag2, sq, t, t2, term, v, se;
			logic [127:0] a, tm, w;
			logic neg, neg2, rej;
			logic [47:0] xs;
			stats_t e;
			rej = 0;
			if (fn == FN_ADD) begin
				if (n_held == '1) begin
					rej = 1;
				end else begin
					xs = {x, 16'd0};
					d = $signed({xs[47], xs}) - $signed({avg_q32[47], avg_q32});
					neg = d[48];
					mag = neg ? 64'(-d) : 64'(d);
					avg_q32 = move_mean(avg_q32, mag, neg, 1, 64'(n_held) + 1);
					d = $signed({xs[47], xs}) - $signed({avg_q32[47], avg_q32});
					neg2 = d[48];
					mag2 = neg2 ? 64'(-d) : 64'(d);
					dev_sum = sat_add(dev_sum, scaled_prod(mag, mag2));
					n_held++;
				end
			end else if (oc == 0) begin
				// An empty partial leaves everything as it is.
			end else if (n_held == 0) begin
				n_held = oc;
				avg_q32 = {omean, 16'd0};
				dev_sum = om2;
			end else if (33'(n_held) + 33'(oc) > 33'h0_FFFF_FFFF) begin
				rej = 1;
			end else begin
				xs = {omean, 16'd0};
				d = $signed({xs[47], xs}) - $signed({avg_q32[47], avg_q32});
				neg = d[48];
				mag = neg ? 64'(-d) : 64'(d);
				sq = scaled_prod(mag, mag);
				a = sq * 64'(n_held);
				t = 64'(a / (64'(n_held) + oc));
				a = (a % (64'(n_held) + oc)) * 64'(oc);
				t2 = 64'(a / (64'(n_held) + oc));
				tm = t * 64'(oc);
				term = sat_add(tm[127:64] != 0 ? '1 : tm[63:0], t2);
				dev_sum = sat_add(sat_add(dev_sum, om2), term);
				avg_q32 = move_mean(avg_q32, mag, neg, 64'(oc), 64'(n_held) + oc);
				n_held = n_held + oc;
			end
			e.count = n_held;
			e.mean = (n_held == 0) ? '0 : avg_q32[47:16];
			e.mean_ok = n_held >= 1;
			e.var_ok = n_held >= 2;
			e.rejected = rej;
			e.variance = '0;
			e.std_err = '0;
			if (n_held >= 2) begin
				v = dev_sum / (64'(n_held) - 1);
				e.variance = (v > 64'hFFFF_FFFF_FFFF) ? '1 : v[47:0];
				w = {64'd0, v} << 16;
				w = w / n_held;
				if (w[127:64] != 0) begin
					e.std_err = '1;
				end else begin
					se = root(w[63:0]);
					e.std_err = (se > 64'hFFFF_FFFF) ? '1 : se[31:0];
				end
			end
			pending.push_back(e);
		endfunction

		task check_result(logic [143:0] data, logic [2:0] flags);
			stats_t e;
			if (pending.size() == 0) begin
				report_mismatch("unexpected beat", data[31:0], 0);
				return;
			end
			e = pending.pop_front();
			if (data[31:0] !== e.count) report_mismatch("total_count", data[31:0], e.count);
			if (data[63:32] !== e.mean) report_mismatch("mean_value", data[63:32], e.mean);
			if (data[111:64] !== e.variance)
				report_mismatch("variance_value", data[111:64], e.variance);
			if (data[143:112] !== e.std_err)
				report_mismatch("std_error", data[143:112], e.std_err);
			if (flags[0] !== e.mean_ok) report_mismatch("mean_valid", flags[0], e.mean_ok);
			if (flags[1] !== e.var_ok) report_mismatch("variance_valid", flags[1], e.var_ok);
			if (flags[2] !== e.rejected) report_mismatch("status", flags[2], e.rejected);
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [143:0] m_tdata;
	logic [2:0]   m_tuser;

	stats_scoreboard board = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;
	bit hold_on = 0;
	bit sending_done = 0;

	running_mean_variance i_dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// Receiver: random stalls, closed entirely during the long hold-off.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
		m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
	end

	// Long receiver hold-off, counted in cycles once requested.
	initial begin
		int left;
		wait (hold_req);
		@(posedge clk);
		hold_on <= 1;
		for (left = 3000; left > 0; left--) @(posedge clk);
		hold_on <= 0;
	end

	task automatic send_beat(input logic fn, input logic [31:0] x, input logic [31:0] oc,
	                         input logic [31:0] omean, input logic [63:0] om2);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= fn;
		s_tdata <= {om2, omean, oc, x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_input(fn, x, oc, omean, om2);
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// Mostly moderate samples so the statistics stay meaningful, some extremes.
	task automatic random_beat();
		logic [31:0] x, oc;
		logic [63:0] om2;
		case ($urandom_range(9))
			0: x = $urandom();
			1: x = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: x = 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(16);
		endcase
		case ($urandom_range(7))
			0: oc = $urandom();
			1: oc = 0;
			default: oc = $urandom_range(50);
		endcase
		case ($urandom_range(5))
			0: om2 = {$urandom(), $urandom()};
			default: om2 = 64'($urandom()) << $urandom_range(20);
		endcase
		send_beat($urandom_range(3) == 0 ? FN_MERGE : FN_ADD, x, oc, $urandom(), om2);
	endtask

	initial begin
		int ph;
		@(posedge arst_n);
		@(posedge clk);
		// Directed: single values, extremes, empty and overflowing merges.
		send_beat(FN_MERGE, 0, 0, 32'h1234, 64'h55);
		send_beat(FN_MERGE, 0, 5, 32'h0003_0000, 64'h0010_0000);
		send_beat(FN_ADD, 32'h7FFF_FFFF, 0, 0, 0);
		send_beat(FN_ADD, 32'h8000_0000, 0, 0, 0);
		send_beat(FN_ADD, 32'hFFFF_FFFF, 0, 0, 0);
		send_beat(FN_MERGE, 0, 0, 0, 0);
		send_beat(FN_MERGE, 0, 32'hFFFF_FFFF, 32'h8000_0000, '1);
		send_beat(FN_MERGE, 0, 3, 32'h7FFF_FFFF, '1);
		send_beat(FN_ADD, 32'h0001_8000, 0, 0, 0);
		// Raise the count to FFFF_FFFC, try overflowing merges, then add and merge.
		send_beat(FN_MERGE, 0, 0, 0, 0);
		send_beat(FN_MERGE, 0, 32'hFFFF_FFF0, 32'h8000_0000, 64'hFFFF_0000_0000_0000);
		send_beat(FN_MERGE, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '1);
		send_beat(FN_MERGE, 0, 15, 32'h7FFF_FFFF, '1);
		send_beat(FN_ADD, 32'h0000_0001, 0, 0, 0);
		send_beat(FN_MERGE, 0, 1, 0, 0);
		wait_drained();
		// Random phases: none, sender idle, receiver stall, both.
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 51 : (ph == 3) ? 24 : 0;
			recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 24 : 0;
			if (ph == 2) hold_req = 1;
			repeat (150) random_beat();
			wait_drained();
		end
		sending_done = 1;
	end

	initial begin
		wait (sending_done);
		repeat (2000) @(posedge clk);
		if (fail_count == 0 && board.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#10000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ running_mean_variance.f @@
+incdir+hdl
hdl/rmv_pkg.sv
hdl/rmv_arith.sv
hdl/running_mean_variance.sv
hdl/rmv_checker.sv
tb/tb_running_mean_variance.sv
